/* sv/bcr_pkg.sv */
// bcr_pkg: shared types and constants of the bank controller with clock registers
// no dependencies; imported by bcr_mapper, bcr_ram and bank_controller_with_rtc
package bcr_pkg;

   // access kinds carried in the request tuser
   typedef enum logic [1:0] {
      KIND_ROM_READ  = 2'd0,
      KIND_ROM_WRITE = 2'd1,
      KIND_RAM_READ  = 2'd2,
      KIND_RAM_WRITE = 2'd3
   } req_kind_type;

   // mapper register window, from rom-area address bits 14:13
   typedef enum logic [1:0] {
      WIN_RAM_ENABLE = 2'd0,
      WIN_ROM_BANK   = 2'd1,
      WIN_RAM_BANK   = 2'd2,
      WIN_LATCH      = 2'd3
   } win_type;

   localparam logic [7:0] RAM_ENABLE_KEY = 8'h0A;
   localparam logic [6:0] ROM_BANK_ONE   = 7'd1;
   localparam logic [7:0] LATCH_FIRST    = 8'h00;
   localparam logic [7:0] LATCH_SECOND   = 8'h01;
   localparam logic [7:0] UNDEF_BYTE     = 8'hFF;
   localparam logic [7:0] DAYS_HIGH_MASK = 8'hC1;
   localparam int         HALT_BIT       = 6;

   // highest bank that maps onto the ram store
   localparam logic [7:0] LAST_STORE_BANK = 8'd3;

   // clock register banks
   localparam logic [7:0] BANK_SECONDS   = 8'h08;
   localparam logic [7:0] BANK_MINUTES   = 8'h09;
   localparam logic [7:0] BANK_HOURS     = 8'h0A;
   localparam logic [7:0] BANK_DAYS_LOW  = 8'h0B;
   localparam logic [7:0] BANK_DAYS_HIGH = 8'h0C;

   // result of the decode stage, before the ram byte is merged in
   typedef struct packed {
      logic        use_ram;
      logic [7:0]  data;
      logic        rom_fetch;
      logic [20:0] rom_address;
      logic        undefined;
   } stage_type;

   // ram port control from the mapper
   typedef struct packed {
      logic rd;
      logic wr;
   } ram_ctrl_type;

endpackage

/* sv/bcr_mapper.sv */
// bcr_mapper: mapper registers, clock registers and access decode
// depends on bcr_pkg; drives the ram port and the decode-stage result
module bcr_mapper #(
   parameter int RAM_BYTES = 32768
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   input  logic                         accept,
   input  bcr_pkg::req_kind_type        kind,
   input  logic [15:0]                  bus_address,
   input  logic [7:0]                   write_byte,
   input  logic [5:0]                   now_seconds,
   input  logic [5:0]                   now_minutes,
   input  logic [4:0]                   now_hours,
   input  logic [8:0]                   now_day_of_year,
   output bcr_pkg::stage_type           stage,
   output bcr_pkg::ram_ctrl_type        ram_ctrl,
   output logic [$clog2(RAM_BYTES)-1:0] ram_index,
   output logic [7:0]                   ram_wdata
);
   import bcr_pkg::*;

   localparam int AW = $clog2(RAM_BYTES);

   logic       timer_present_ff, timer_present_in;
   logic       ram_enabled_ff, ram_enabled_in;
   logic [6:0] rom_bank_ff, rom_bank_in;
   logic [7:0] ram_bank_ff, ram_bank_in;
   logic [7:0] latch_prev_ff, latch_prev_in;
   logic       latch_valid_ff, latch_valid_in;
   logic       latch_open_ff, latch_open_in;
   logic [5:0] seconds_ff, seconds_in;
   logic [5:0] minutes_ff, minutes_in;
   logic [4:0] hours_ff, hours_in;
   logic [7:0] days_low_ff, days_low_in;
   logic [7:0] days_high_ff, days_high_in;

   logic       reload;
   logic       bank_is_ram;
   logic       clock_access;
   logic [14:0] full_index;
   win_type    win;

   assign win          = win_type'(bus_address[14:13]);
   assign bank_is_ram  = (ram_bank_ff[7:2] == 6'd0);
   assign clock_access = ram_enabled_ff && !bank_is_ram && timer_present_ff;
   assign reload       = (kind == KIND_RAM_READ) && !days_high_ff[HALT_BIT];
   assign full_index   = {ram_bank_ff[1:0], bus_address[12:0]};

   // ram port
   assign ram_index      = full_index[AW-1:0];
   assign ram_wdata      = write_byte;
   assign ram_ctrl.rd    = accept && (kind == KIND_RAM_READ) && ram_enabled_ff && bank_is_ram;
   assign ram_ctrl.wr    = accept && (kind == KIND_RAM_WRITE) && ram_enabled_ff && bank_is_ram;

   // register next values
   always_comb begin
      timer_present_in = csr_wr_en ? csr_wr_data : timer_present_ff;
      ram_enabled_in   = ram_enabled_ff;
      rom_bank_in      = rom_bank_ff;
      ram_bank_in      = ram_bank_ff;
      latch_prev_in    = latch_prev_ff;
      latch_valid_in   = latch_valid_ff;
      latch_open_in    = latch_open_ff;
      seconds_in       = seconds_ff;
      minutes_in       = minutes_ff;
      hours_in         = hours_ff;
      days_low_in      = days_low_ff;
      days_high_in     = days_high_ff;
      if (accept) begin
         case (kind)
            KIND_ROM_WRITE: begin
               unique case (win)
                  WIN_RAM_ENABLE: ram_enabled_in = (write_byte == RAM_ENABLE_KEY);
                  WIN_ROM_BANK: begin
                     rom_bank_in = (write_byte[6:0] == 7'd0) ? ROM_BANK_ONE
                                                             : write_byte[6:0];
                  end
                  WIN_RAM_BANK: ram_bank_in = write_byte;
                  WIN_LATCH: begin
                     latch_open_in  = latch_valid_ff && (latch_prev_ff == LATCH_FIRST)
                                      && (write_byte == LATCH_SECOND);
                     latch_prev_in  = write_byte;
                     latch_valid_in = 1'b1;
                  end
                  default: ;
               endcase
            end
            KIND_RAM_READ: begin
               if (reload) begin
                  seconds_in   = now_seconds;
                  minutes_in   = now_minutes;
                  hours_in     = now_hours;
                  days_low_in  = now_day_of_year[7:0];
                  days_high_in = {7'd0, now_day_of_year[8]};
               end
            end
            KIND_RAM_WRITE: begin
               if (clock_access) begin
                  unique case (ram_bank_ff)
                     BANK_SECONDS:   seconds_in   = write_byte[5:0];
                     BANK_MINUTES:   minutes_in   = write_byte[5:0];
                     BANK_HOURS:     hours_in     = write_byte[4:0];
                     BANK_DAYS_LOW:  days_low_in  = write_byte;
                     BANK_DAYS_HIGH: days_high_in = write_byte & DAYS_HIGH_MASK;
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   // decode-stage result, clock bytes seen after any reload
   always_comb begin
      stage.use_ram     = 1'b0;
      stage.data        = UNDEF_BYTE;
      stage.rom_fetch   = 1'b0;
      stage.rom_address = 21'd0;
      stage.undefined   = 1'b1;
      case (kind)
         KIND_ROM_READ: begin
            stage.data        = 8'd0;
            stage.undefined   = 1'b0;
            stage.rom_fetch   = 1'b1;
            stage.rom_address = bus_address[14] ? {rom_bank_ff, bus_address[13:0]}
                                                : {6'd0, bus_address[14:0]};
         end
         KIND_RAM_READ: begin
            if (ram_enabled_ff && bank_is_ram) begin
               stage.use_ram   = 1'b1;
               stage.undefined = 1'b0;
            end else if (clock_access && latch_open_ff) begin
               stage.undefined = 1'b0;
               unique case (ram_bank_ff)
                  BANK_SECONDS:   stage.data = {2'd0, seconds_in};
                  BANK_MINUTES:   stage.data = {2'd0, minutes_in};
                  BANK_HOURS:     stage.data = {3'd0, hours_in};
                  BANK_DAYS_LOW:  stage.data = days_low_in;
                  BANK_DAYS_HIGH: stage.data = days_high_in;
                  default:        stage.undefined = 1'b1;
               endcase
            end
         end
         default: ;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_present_ff <= 1'b0;
         ram_enabled_ff   <= 1'b0;
         rom_bank_ff      <= ROM_BANK_ONE;
         ram_bank_ff      <= 8'd0;
         latch_prev_ff    <= 8'd0;
         latch_valid_ff   <= 1'b0;
         latch_open_ff    <= 1'b0;
         seconds_ff       <= 6'd0;
         minutes_ff       <= 6'd0;
         hours_ff         <= 5'd0;
         days_low_ff      <= 8'd0;
         days_high_ff     <= 8'd0;
      end else begin
         timer_present_ff <= timer_present_in;
         ram_enabled_ff   <= ram_enabled_in;
         rom_bank_ff      <= rom_bank_in;
         ram_bank_ff      <= ram_bank_in;
         latch_prev_ff    <= latch_prev_in;
         latch_valid_ff   <= latch_valid_in;
         latch_open_ff    <= latch_open_in;
         seconds_ff       <= seconds_in;
         minutes_ff       <= minutes_in;
         hours_ff         <= hours_in;
         days_low_ff      <= days_low_in;
         days_high_ff     <= days_high_in;
      end
   end

endmodule

/* sv/bcr_ram.sv */
// bcr_ram: cartridge ram store, one port, registered read data
// depends on bcr_pkg for the port control struct
module bcr_ram #(
   parameter int RAM_BYTES = 32768
) (
   input  logic                         clock,
   input  bcr_pkg::ram_ctrl_type        ram_ctrl,
   input  logic [$clog2(RAM_BYTES)-1:0] ram_index,
   input  logic [7:0]                   ram_wdata,
   output logic [7:0]                   ram_rdata
);
   import bcr_pkg::*;

   logic [7:0] ram_store [RAM_BYTES];
   logic [7:0] rdata_ff;

   assign ram_rdata = rdata_ff;

   // write and read; read data holds between reads
   always_ff @(posedge clock) begin
      if (ram_ctrl.wr) begin
         ram_store[ram_index] <= ram_wdata;
      end
      if (ram_ctrl.rd) begin
         rdata_ff <= ram_store[ram_index];
      end
   end

endmodule

/* sv/bank_controller_with_rtc.sv */
// bank_controller_with_rtc: cartridge bank mapper with clock registers, top level
// depends on bcr_pkg, bcr_mapper and bcr_ram
//
//   channel  direction  carries                              per transfer
//   req_     in         one bus access (kind in tuser)       0 or 1 result
//   rsp_     out        read byte or rom address + flags     one per read
//   csr_     in         timer_present                        write only
//
// one access is accepted per cycle while req_tready is high; a read result
// is loaded into the middle stage, together with the ram byte, when its
// transfer is taken, and then into the output register
// writes update mapper or ram in the cycle they are taken; no result
// a stalled result holds the pipeline; req_tready stays high while the
// middle stage is empty or can move on
// reset clears all control state; ram contents are undefined until written
// RAM_BYTES must be a power of two
module bank_controller_with_rtc #(
   parameter int RAM_BYTES = 32768
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] bus_address, [23:16] write_byte, [29:24] now_seconds,
   // [35:30] now_minutes, [40:36] now_hours, [49:41] now_day_of_year
   input  logic [55:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]  req_tuser,
   // result
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data, [28:8] rom_address
   output logic [31:0] rsp_tdata,
   // [0] rom_fetch, [1] data_undefined
   output logic [1:0]  rsp_tuser
);
   import bcr_pkg::*;

   localparam int AW = $clog2(RAM_BYTES);

   logic          accept;
   logic          advance;
   req_kind_type  kind;
   stage_type     stage;
   ram_ctrl_type  ram_ctrl;
   logic [AW-1:0] ram_index;
   logic [7:0]    ram_wdata;
   logic [7:0]    ram_rdata;

   logic          s1_valid_ff, s1_valid_in;
   stage_type     s1_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_data_ff;
   logic [1:0]    rsp_user_ff;
   logic [7:0]    read_byte;

   assign kind       = req_kind_type'(req_tuser);
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   bcr_mapper #(.RAM_BYTES(RAM_BYTES)) u_mapper (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .accept          (accept),
      .kind            (kind),
      .bus_address     (req_tdata[15:0]),
      .write_byte      (req_tdata[23:16]),
      .now_seconds     (req_tdata[29:24]),
      .now_minutes     (req_tdata[35:30]),
      .now_hours       (req_tdata[40:36]),
      .now_day_of_year (req_tdata[49:41]),
      .stage           (stage),
      .ram_ctrl        (ram_ctrl),
      .ram_index       (ram_index),
      .ram_wdata       (ram_wdata)
   );

   bcr_ram #(.RAM_BYTES(RAM_BYTES)) u_ram (
      .clock     (clock),
      .ram_ctrl  (ram_ctrl),
      .ram_index (ram_index),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata)
   );

   // middle stage valid: only reads carry a result
   always_comb begin
      if (accept) begin
         s1_valid_in = (kind == KIND_ROM_READ) || (kind == KIND_RAM_READ);
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   // merge ram byte into the result
   assign read_byte = s1_ff.use_ram ? ram_rdata : s1_ff.data;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= stage;
      end
      if (advance) begin
         rsp_data_ff <= {3'd0, s1_ff.rom_address, read_byte};
         rsp_user_ff <= {s1_ff.undefined, s1_ff.rom_fetch};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // a full middle stage behind a stalled result blocks new transfers
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("transfer taken while pipeline is blocked");

   // rom fetch and undefined data never flagged together
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("rom fetch flagged undefined");

   // undefined reads carry the fill byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[7:0] == UNDEF_BYTE)
      else $error("undefined read with wrong byte");

   // the ram port moves only with a request transfer
   assert property (@(posedge clock) disable iff (reset)
      ram_ctrl.rd || ram_ctrl.wr |-> accept && !(ram_ctrl.rd && ram_ctrl.wr))
      else $error("ram access without transfer");

endmodule
